// File: rtl/cktb_pkg.sv
// ----------------------------------------------------------------------------
// cktb_pkg
// Shared types and constants for the CAN key to button translator: command
// codes, key codes, register reset values and the queue entry format.
// ----------------------------------------------------------------------------
package cktb_pkg;

    // button commands sent to the head unit
    typedef enum logic [2:0] {
        CMD_RELEASE     = 3'd0,
        CMD_NEXT        = 3'd1,
        CMD_PREV        = 3'd2,
        CMD_MUTE        = 3'd3,
        CMD_DISPLAY_OFF = 3'd4
    } cmd_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_WHEEL_MASK = 2'd0,
        REG_PANEL_MASK = 2'd1,
        REG_AUX_SOURCE = 2'd2,
        REG_HOLD_TIME  = 2'd3
    } reg_idx_t;

    localparam int unsigned MASK_W = 29;
    localparam int unsigned CFG_W  = 29;

    // register reset values
    localparam logic [MASK_W-1:0] WHEEL_MASK_RST = 29'h1043_8040;
    localparam logic [MASK_W-1:0] PANEL_MASK_RST = 29'h10AD_6080;
    localparam logic [7:0]        AUX_SOURCE_RST = 8'h08;
    localparam logic [15:0]       HOLD_TIME_RST  = 16'd2000;

    // frame byte codes
    localparam logic [7:0] KIND_SOURCE   = 8'h00;
    localparam logic [7:0] SOURCE_MARK   = 8'h12;
    localparam logic [7:0] KIND_PANEL    = 8'h03;
    localparam logic [7:0] KEY_NONE      = 8'h00;
    localparam logic [7:0] KEY_WHEEL_MUTE = 8'h07;
    localparam logic [7:0] STATE_PRESS   = 8'h00;
    localparam logic [3:0] WHEEL_LENGTH  = 4'd1;

    // key table codes
    localparam logic [7:0] KEY_NEXT_A = 8'h03;
    localparam logic [7:0] KEY_NEXT_B = 8'h13;
    localparam logic [7:0] KEY_PREV_A = 8'h04;
    localparam logic [7:0] KEY_PREV_B = 8'h19;
    localparam logic [7:0] KEY_MUTE   = 8'h18;

    // result of a key table lookup
    typedef struct packed {
        logic hit;
        cmd_t cmd;
    } key_cmd_t;

    // one queue entry: the one or two commands caused by an item
    typedef struct packed {
        logic two;
        cmd_t first;
        cmd_t second;
    } entry_t;

    // key table
    function automatic key_cmd_t key_lookup(input logic [7:0] key);
        key_cmd_t res;
        res.hit = 1'b1;
        res.cmd = CMD_RELEASE;
        unique case (key)
            KEY_NEXT_A, KEY_NEXT_B: res.cmd = CMD_NEXT;
            KEY_PREV_A, KEY_PREV_B: res.cmd = CMD_PREV;
            KEY_MUTE:               res.cmd = CMD_MUTE;
            default:                res.hit = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// File: rtl/cktb_front.sv
// ----------------------------------------------------------------------------
// cktb_front
// Accepts frames, classifies them (source change, wheel key, panel key),
// updates the button state and pushes the resulting commands as one entry.
// ----------------------------------------------------------------------------
module cktb_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [31:0]           frame_id,
    input  logic [3:0]            frame_length,
    input  logic [7:0]            byte_zero,
    input  logic [7:0]            byte_one,
    input  logic [7:0]            byte_two,
    input  logic [7:0]            byte_seven,
    input  logic [31:0]           now_ms,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [cktb_pkg::CFG_W-1:0] cfg_data,
    input  logic                  queue_full,
    output logic                  push,
    output cktb_pkg::entry_t      push_entry
);
    import cktb_pkg::*;

    logic [MASK_W-1:0] wheel_mask_reg;
    logic [MASK_W-1:0] panel_mask_reg;
    logic [7:0]        aux_source_reg;
    logic [15:0]       hold_time_reg;

    logic [7:0]  media_source_reg, media_source_next;
    logic        pressed_reg, pressed_next;
    logic        holding_reg, holding_next;
    logic [31:0] mute_start_reg, mute_start_next;

    logic        accept;
    logic        panel_hit, wheel_hit;
    logic        src_change, wheel_frame, panel_frame;
    logic [7:0]  source_1;
    logic        pressed_1, holding_1, pressed_2, holding_2;
    logic        emit_1, emit_2, emit_3;
    cmd_t        cmd_2, cmd_3;
    key_cmd_t    wheel_key, panel_key;
    logic [31:0] elapsed;
    logic        hold_done;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wheel_mask_reg <= WHEEL_MASK_RST;
            panel_mask_reg <= PANEL_MASK_RST;
            aux_source_reg <= AUX_SOURCE_RST;
            hold_time_reg  <= HOLD_TIME_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_WHEEL_MASK: wheel_mask_reg <= cfg_data;
                REG_PANEL_MASK: panel_mask_reg <= cfg_data;
                REG_AUX_SOURCE: aux_source_reg <= cfg_data[7:0];
                REG_HOLD_TIME:  hold_time_reg  <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    // frame classification
    assign accept      = in_valid && !queue_full;
    assign panel_hit   = (frame_id[MASK_W-1:0] & panel_mask_reg) == panel_mask_reg;
    assign wheel_hit   = (frame_id[MASK_W-1:0] & wheel_mask_reg) == wheel_mask_reg;
    assign src_change  = panel_hit && byte_zero == KIND_SOURCE && byte_one == SOURCE_MARK;
    assign wheel_frame = wheel_hit && frame_length == WHEEL_LENGTH;
    assign wheel_key   = key_lookup(byte_zero);
    assign panel_key   = key_lookup(byte_two);
    assign elapsed     = now_ms - mute_start_reg;
    assign hold_done   = elapsed >= {16'd0, hold_time_reg};

    // source change step
    always_comb
    begin
        source_1  = src_change ? byte_two : media_source_reg;
        emit_1    = src_change && media_source_reg == aux_source_reg
                    && byte_two != aux_source_reg && pressed_reg;
        pressed_1 = emit_1 ? 1'b0 : pressed_reg;
        holding_1 = emit_1 ? 1'b0 : holding_reg;
    end

    // wheel key step
    always_comb
    begin
        pressed_2       = pressed_1;
        holding_2       = holding_1;
        mute_start_next = mute_start_reg;
        emit_2          = 1'b0;
        cmd_2           = CMD_RELEASE;
        if (wheel_frame)
        begin
            if (byte_zero == KEY_NONE)
            begin
                if (pressed_1)
                begin
                    pressed_2 = 1'b0;
                    holding_2 = 1'b0;
                    emit_2    = 1'b1;
                end
            end
            else if (source_1 == aux_source_reg)
            begin
                pressed_2 = 1'b1;
                if (byte_zero == KEY_WHEEL_MUTE)
                begin
                    if (!holding_1)
                    begin
                        mute_start_next = now_ms;
                        holding_2       = 1'b1;
                    end
                    else if (hold_done)
                    begin
                        emit_2    = 1'b1;
                        cmd_2     = CMD_DISPLAY_OFF;
                        holding_2 = 1'b0;
                    end
                end
                else
                begin
                    holding_2 = 1'b0;
                    emit_2    = wheel_key.hit;
                    cmd_2     = wheel_key.cmd;
                end
            end
        end
    end

    // panel key step
    always_comb
    begin
        panel_frame  = panel_hit && byte_zero == KIND_PANEL && source_1 == aux_source_reg;
        pressed_next = pressed_2;
        emit_3       = 1'b0;
        cmd_3        = CMD_RELEASE;
        if (panel_frame)
        begin
            if (byte_seven == STATE_PRESS)
            begin
                emit_3       = panel_key.hit;
                cmd_3        = panel_key.cmd;
                pressed_next = 1'b1;
            end
            else
            begin
                emit_3       = 1'b1;
                pressed_next = 1'b0;
            end
        end
        media_source_next = source_1;
        holding_next      = holding_2;
    end

    // pack the first two commands into one entry
    always_comb
    begin
        push_entry.first  = emit_1 ? CMD_RELEASE : (emit_2 ? cmd_2 : cmd_3);
        push_entry.second = emit_1 ? (emit_2 ? cmd_2 : cmd_3) : cmd_3;
        push_entry.two    = emit_1 ? (emit_2 || emit_3) : (emit_2 && emit_3);
        push              = accept && (emit_1 || emit_2 || emit_3);
    end

    // button state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            media_source_reg <= '0;
            pressed_reg      <= 1'b0;
            holding_reg      <= 1'b0;
            mute_start_reg   <= '0;
        end
        else if (accept)
        begin
            media_source_reg <= media_source_next;
            pressed_reg      <= pressed_next;
            holding_reg      <= holding_next;
            mute_start_reg   <= mute_start_next;
        end
    end

endmodule

// File: rtl/cktb_queue.sv
// ----------------------------------------------------------------------------
// cktb_queue
// Short queue of command entries between the front and the back.
// ----------------------------------------------------------------------------
module cktb_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cktb_pkg::entry_t push_entry,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output cktb_pkg::entry_t head
);
    import cktb_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // no write into a full queue, no read from an empty one
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");

    // fill count bounded by depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

endmodule

// File: rtl/cktb_back.sv
// ----------------------------------------------------------------------------
// cktb_back
// Takes entries from the queue and delivers their commands one per item
// through the output register, marking the final command of each frame.
// ----------------------------------------------------------------------------
module cktb_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  cktb_pkg::entry_t head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       command,
    output logic             last
);
    import cktb_pkg::*;

    logic out_valid_reg, out_valid_next;
    cmd_t command_reg, command_next;
    logic last_reg, last_next;
    logic sel_reg, sel_next;
    logic load;

    // load a new command when the output register is free or being taken
    always_comb
    begin
        load           = head_valid && (!out_valid_reg || !out_stall);
        pop            = load && (sel_reg || !head.two);
        out_valid_next = load || (out_valid_reg && out_stall);
        command_next   = command_reg;
        last_next      = last_reg;
        sel_next       = sel_reg;
        if (load)
        begin
            command_next = sel_reg ? head.second : head.first;
            last_next    = sel_reg || !head.two;
            sel_next     = head.two && !sel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            sel_reg       <= sel_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        command_reg <= command_next;
        last_reg    <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign command   = command_reg;
    assign last      = last_reg;

    // second half of a two-command entry keeps its entry at the queue head
    a_sel_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> head_valid && head.two)
        else $error("second command pending without its entry");

    // an entry is popped only on its final command
    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> last_reg && out_valid_reg)
        else $error("entry popped before its final command");

    // pending second command is preceded by a first one on the output
    a_sel_after_first: assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg |-> out_valid_reg && !last_reg)
        else $error("second command without a first one shown");

endmodule

// File: rtl/can_key_to_button_translator.sv
// ----------------------------------------------------------------------------
// can_key_to_button_translator
// Turns received CAN frames into head unit button commands.
// ----------------------------------------------------------------------------
// A frame yields zero, one or two commands; each command leaves on its own
// output item, the final one of a frame with last set. The front takes one
// frame per cycle while the queue of DEPTH entries has room; the single output
// register delivers one command per cycle while out_stall is low, so a frame
// that gives two commands takes two output items and frames giving none never
// reach the output. Configuration must be written by the user through the plain
// write port while no frame is in flight; the block does not enforce it.
module can_key_to_button_translator #(
    parameter int unsigned DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] frame_id,
    input  logic [3:0]  frame_length,
    input  logic [7:0]  byte_zero,
    input  logic [7:0]  byte_one,
    input  logic [7:0]  byte_two,
    input  logic [7:0]  byte_seven,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  command,
    output logic        last,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [cktb_pkg::CFG_W-1:0] cfg_data
);
    import cktb_pkg::*;

    logic   push, pop, full, head_valid;
    entry_t push_entry, head;

    assign in_stall = full;

    // classification and state
    cktb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .frame_id     (frame_id),
        .frame_length (frame_length),
        .byte_zero    (byte_zero),
        .byte_one     (byte_one),
        .byte_two     (byte_two),
        .byte_seven   (byte_seven),
        .now_ms       (now_ms),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .queue_full   (full),
        .push         (push),
        .push_entry   (push_entry)
    );

    // command queue
    cktb_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    // command delivery
    cktb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .command    (command),
        .last       (last)
    );

endmodule

// File: tb/can_button_checker.sv
// ----------------------------------------------------------------------------
// can_button_checker
// Watches the frame, command and register channels of the CAN key to button
// translator. It keeps its own copy of the registers and of the source,
// pressed and mute-hold state, predicts the commands of every accepted frame
// and compares each accepted command item, in order, with the oldest one
// predicted. It hands the mismatch count and the number of commands still
// outstanding to the testbench top.
// ----------------------------------------------------------------------------
module can_button_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [31:0] frame_id,
    input  logic [3:0]  frame_length,
    input  logic [7:0]  byte_zero,
    input  logic [7:0]  byte_one,
    input  logic [7:0]  byte_two,
    input  logic [7:0]  byte_seven,
    input  logic [31:0] now_ms,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  command,
    input  logic        last,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [cktb_pkg::CFG_W-1:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    import cktb_pkg::*;

    // one predicted command item
    typedef struct packed {
        cmd_t cmd;
        logic last;
    } button_item_t;

    button_item_t expected_cmds[$];

    // register copy
    logic [MASK_W-1:0] wheel_mask;
    logic [MASK_W-1:0] panel_mask;
    logic [7:0]        aux_code;
    logic [15:0]       hold_ms;

    // translator state copy
    logic [7:0]  source;
    logic        pressed;
    logic        mute_held;
    logic [31:0] mute_since;

    // commands of the frame being predicted
    cmd_t frame_cmds [2];
    int   frame_n;

    int errors = 0;
    int waiting = 0;

    assign fail_count = errors;
    assign pending    = waiting;

    // key table: returns 1 when the key maps to a command
    function automatic logic key_command(input logic [7:0] key, output cmd_t cmd);
        cmd = CMD_RELEASE;
        case (key)
            KEY_NEXT_A, KEY_NEXT_B: cmd = CMD_NEXT;
            KEY_PREV_A, KEY_PREV_B: cmd = CMD_PREV;
            KEY_MUTE:               cmd = CMD_MUTE;
            default:                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // at most two commands per frame
    task automatic note_command(input cmd_t c);
        if (frame_n < 2)
        begin
            frame_cmds[frame_n] = c;
            frame_n++;
        end
    endtask

    // source change, wheel key and panel key checks, in that order
    task automatic predict_commands(
        input logic [31:0] id,
        input logic [3:0]  len,
        input logic [7:0]  b0,
        input logic [7:0]  b1,
        input logic [7:0]  b2,
        input logic [7:0]  b7,
        input logic [31:0] stamp
    );
        logic         panel_hit;
        logic         wheel_hit;
        logic         was_aux;
        cmd_t         key_cmd;
        button_item_t entry;
        panel_hit = (id & {3'b000, panel_mask}) == {3'b000, panel_mask};
        wheel_hit = (id & {3'b000, wheel_mask}) == {3'b000, wheel_mask};
        frame_n = 0;

        // source change, forced release when leaving aux with a key down
        if (panel_hit && b0 == KIND_SOURCE && b1 == SOURCE_MARK)
        begin
            was_aux = (source == aux_code);
            source = b2;
            if (was_aux && source != aux_code && pressed)
            begin
                pressed = 1'b0;
                mute_held = 1'b0;
                note_command(CMD_RELEASE);
            end
        end

        // steering wheel keys
        if (wheel_hit && len == WHEEL_LENGTH)
        begin
            if (b0 == KEY_NONE)
            begin
                if (pressed)
                begin
                    pressed = 1'b0;
                    mute_held = 1'b0;
                    note_command(CMD_RELEASE);
                end
            end
            else if (source == aux_code)
            begin
                pressed = 1'b1;
                if (b0 == KEY_WHEEL_MUTE)
                begin
                    if (!mute_held)
                    begin
                        mute_since = stamp;
                        mute_held = 1'b1;
                    end
                    else if ((stamp - mute_since) >= {16'd0, hold_ms})
                    begin
                        note_command(CMD_DISPLAY_OFF);
                        mute_held = 1'b0;
                    end
                end
                else
                begin
                    mute_held = 1'b0;
                    if (key_command(b0, key_cmd))
                        note_command(key_cmd);
                end
            end
        end

        // panel media keys
        if (panel_hit && b0 == KIND_PANEL && source == aux_code)
        begin
            if (b7 == STATE_PRESS)
            begin
                if (key_command(b2, key_cmd))
                    note_command(key_cmd);
                pressed = 1'b1;
            end
            else
            begin
                note_command(CMD_RELEASE);
                pressed = 1'b0;
            end
        end

        for (int k = 0; k < frame_n; k++)
        begin
            entry.cmd  = frame_cmds[k];
            entry.last = (k == frame_n - 1);
            expected_cmds.push_back(entry);
        end
    endtask

    // track registers, predict on accepted frames, compare accepted commands
    always @(posedge clk or negedge rst_n)
    begin
        button_item_t want;
        if (!rst_n)
        begin
            wheel_mask = WHEEL_MASK_RST;
            panel_mask = PANEL_MASK_RST;
            aux_code   = AUX_SOURCE_RST;
            hold_ms    = HOLD_TIME_RST;
            source     = 8'd0;
            pressed    = 1'b0;
            mute_held  = 1'b0;
            mute_since = 32'd0;
            expected_cmds.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_WHEEL_MASK: wheel_mask = cfg_data[MASK_W-1:0];
                    REG_PANEL_MASK: panel_mask = cfg_data[MASK_W-1:0];
                    REG_AUX_SOURCE: aux_code   = cfg_data[7:0];
                    REG_HOLD_TIME:  hold_ms    = cfg_data[15:0];
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                predict_commands(frame_id, frame_length, byte_zero, byte_one,
                                 byte_two, byte_seven, now_ms);

            if (out_valid && !out_stall)
            begin
                if (expected_cmds.size() == 0)
                begin
                    $display("%0t: unexpected item: expected none, got command %0d last %0b",
                             $time, command, last);
                    errors++;
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (command !== want.cmd)
                    begin
                        $display("%0t: command mismatch: expected %0d, got %0d",
                                 $time, want.cmd, command);
                        errors++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last mismatch: expected %0b, got %0b",
                                 $time, want.last, last);
                        errors++;
                    end
                end
            end
        end
        waiting = expected_cmds.size();
    end

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives CAN frames and register writes into the translator and stalls its
// command output. A short directed run covers every key, the mute hold
// boundary and timer wrap, forced release on leaving aux and two-command
// frames; then phases of random, mostly well-formed frames run under
// several register settings and idle patterns. The checker does the
// prediction; this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import cktb_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int ITEMS_PER_PHASE = 88;
    localparam int DRAIN_CYCLES    = 12;
    localparam int PHASES          = 8;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic [31:0]       frame_id     = 32'd0;
    logic [3:0]        frame_length = 4'd0;
    logic [7:0]        byte_zero    = 8'd0;
    logic [7:0]        byte_one     = 8'd0;
    logic [7:0]        byte_two     = 8'd0;
    logic [7:0]        byte_seven   = 8'd0;
    logic [31:0]       now_ms       = 32'd0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic [2:0]        command;
    logic              last;
    logic              cfg_write    = 1'b0;
    logic [1:0]        cfg_index    = REG_WHEEL_MASK;
    logic [CFG_W-1:0]  cfg_data     = '0;

    int fail_count;
    int pending;

    // idle pattern and long hold-off control
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int cycles        = 0;

    // current settings as written, used to shape frames
    logic [MASK_W-1:0] cur_wheel = WHEEL_MASK_RST;
    logic [MASK_W-1:0] cur_panel = PANEL_MASK_RST;
    logic [7:0]        cur_aux   = AUX_SOURCE_RST;
    logic [15:0]       cur_hold  = HOLD_TIME_RST;
    logic [31:0]       clock_ms  = 32'd0;

    can_key_to_button_translator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .frame_id     (frame_id),
        .frame_length (frame_length),
        .byte_zero    (byte_zero),
        .byte_one     (byte_one),
        .byte_two     (byte_two),
        .byte_seven   (byte_seven),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .command      (command),
        .last         (last),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    can_button_checker command_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .frame_id     (frame_id),
        .frame_length (frame_length),
        .byte_zero    (byte_zero),
        .byte_one     (byte_one),
        .byte_two     (byte_two),
        .byte_seven   (byte_seven),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .command      (command),
        .last         (last),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // clock
    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // command receiver: random stalls, or a long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_OFF_CYCLES;
            out_stall   <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // register write, one per call
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic apply_settings(
        input logic [CFG_W-1:0] wheel,
        input logic [CFG_W-1:0] panel,
        input logic [CFG_W-1:0] aux,
        input logic [CFG_W-1:0] hold
    );
        write_reg(REG_WHEEL_MASK, wheel);
        write_reg(REG_PANEL_MASK, panel);
        write_reg(REG_AUX_SOURCE, aux);
        write_reg(REG_HOLD_TIME, hold);
        cur_wheel = wheel[MASK_W-1:0];
        cur_panel = panel[MASK_W-1:0];
        cur_aux   = aux[7:0];
        cur_hold  = hold[15:0];
    endtask

    // offer one frame item, with a random gap first, and wait for acceptance
    task automatic offer_frame(
        input logic [31:0] id,
        input logic [3:0]  len,
        input logic [7:0]  b0,
        input logic [7:0]  b1,
        input logic [7:0]  b2,
        input logic [7:0]  b7,
        input logic [31:0] stamp
    );
        while ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid     <= 1'b1;
        frame_id     <= id;
        frame_length <= len;
        byte_zero    <= b0;
        byte_one     <= b1;
        byte_two     <= b2;
        byte_seven   <= b7;
        now_ms       <= stamp;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // stop sending and wait until every predicted command has come out
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // key codes weighted toward the table and the special keys
    function automatic logic [7:0] pick_key();
        case ($urandom_range(8))
            0:       return KEY_NEXT_A;
            1:       return KEY_NEXT_B;
            2:       return KEY_PREV_A;
            3:       return KEY_PREV_B;
            4:       return KEY_MUTE;
            5:       return KEY_WHEEL_MUTE;
            6:       return KEY_NONE;
            default: return 8'($urandom);
        endcase
    endfunction

    // time advance, often close to the mute hold time
    function automatic logic [31:0] time_step(input logic [15:0] hold);
        case ($urandom_range(9))
            0:          return 32'd0;
            1, 2, 3:    return 32'($urandom_range(300));
            4, 5:       return {17'd0, hold[15:1]} + 32'($urandom_range(3));
            6, 7:       return {16'd0, hold} - 32'd1 + 32'($urandom_range(2));
            default:    return $urandom;
        endcase
    endfunction

    // one random frame or mute sequence; useful is 0 for plain noise
    task automatic random_frame(output bit useful);
        logic [31:0] id;
        id = $urandom;
        clock_ms = clock_ms + time_step(cur_hold);
        useful = 1'b1;
        case ($urandom_range(19))
            // source change, half of them to aux
            0, 1, 2:
                offer_frame(id | {3'b000, cur_panel}, 4'($urandom_range(8)), KIND_SOURCE,
                            SOURCE_MARK, $urandom_range(1) ? cur_aux : 8'($urandom),
                            8'($urandom), clock_ms);
            // steering wheel key, mostly with the right length
            3, 4, 5, 6, 7, 8, 9:
                offer_frame(id | {3'b000, cur_wheel},
                            $urandom_range(9) == 0 ? 4'($urandom_range(8)) : WHEEL_LENGTH,
                            pick_key(), 8'($urandom), 8'($urandom), 8'($urandom),
                            clock_ms);
            // panel media key, mostly presses
            10, 11, 12, 13, 14:
                offer_frame(id | {3'b000, cur_panel}, 4'($urandom_range(8)), KIND_PANEL,
                            8'($urandom), pick_key(),
                            $urandom_range(2) != 0 ? STATE_PRESS : 8'($urandom),
                            clock_ms);
            // mute held to one below the hold time, then to exactly it
            15, 16:
            begin
                offer_frame(id | {3'b000, cur_wheel}, WHEEL_LENGTH, KEY_WHEEL_MUTE,
                            8'($urandom), 8'($urandom), 8'($urandom), clock_ms);
                clock_ms = clock_ms + {16'd0, cur_hold} - 32'd1;
                offer_frame(id | {3'b000, cur_wheel}, WHEEL_LENGTH, KEY_WHEEL_MUTE,
                            8'($urandom), 8'($urandom), 8'($urandom), clock_ms);
                clock_ms = clock_ms + 32'd1;
                offer_frame(id | {3'b000, cur_wheel}, WHEEL_LENGTH, KEY_WHEEL_MUTE,
                            8'($urandom), 8'($urandom), 8'($urandom), clock_ms);
            end
            // noise
            default:
            begin
                useful = 1'b0;
                offer_frame($urandom, 4'($urandom_range(8)), 8'($urandom), 8'($urandom),
                            8'($urandom), 8'($urandom), $urandom);
            end
        endcase
    endtask

    // stimulus and verdict
    initial
    begin
        logic [31:0] wheel_id;
        logic [31:0] panel_id;
        bit          got;
        int          useful;
        wheel_id = {3'b000, WHEEL_MASK_RST};
        panel_id = {3'b000, PANEL_MASK_RST};

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // nothing matches either mask
        offer_frame(32'd0, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 32'd0);
        // release with nothing pressed, key outside aux
        offer_frame(wheel_id, WHEEL_LENGTH, KEY_NONE, 8'h00, 8'h00, 8'h00, 32'd0);
        offer_frame(wheel_id, WHEEL_LENGTH, KEY_NEXT_A, 8'h00, 8'h00, 8'h00, 32'd0);
        // switch to aux; length does not matter for a source change
        offer_frame(panel_id, 4'd0, KIND_SOURCE, SOURCE_MARK, AUX_SOURCE_RST, 8'hFF, 32'd0);
        // every wheel key, an unknown one, then a release
        offer_frame(wheel_id, WHEEL_LENGTH, KEY_NEXT_A, 8'h00, 8'h00, 8'h00, 32'd10);
        offer_frame(wheel_id, WHEEL_LENGTH, KEY_NEXT_B, 8'h00, 8'h00, 8'h00, 32'd20);
        offer_frame(wheel_id, WHEEL_LENGTH, KEY_PREV_A, 8'h00, 8'h00, 8'h00, 32'd30);
        offer_frame(wheel_id, WHEEL_LENGTH, KEY_PREV_B, 8'h00, 8'h00, 8'h00, 32'd40);
        offer_frame(wheel_id, WHEEL_LENGTH, KEY_MUTE, 8'h00, 8'h00, 8'h00, 32'd50);
        offer_frame(wheel_id, WHEEL_LENGTH, 8'h55, 8'hFF, 8'hFF, 8'hFF, 32'd60);
        offer_frame(wheel_id, WHEEL_LENGTH, KEY_NONE, 8'h00, 8'h00, 8'h00, 32'd70);
        // mute hold: one short of the hold time, then exactly at it
        offer_frame(wheel_id, WHEEL_LENGTH, KEY_WHEEL_MUTE, 8'h00, 8'h00, 8'h00, 32'd1000);
        offer_frame(wheel_id, WHEEL_LENGTH, KEY_WHEEL_MUTE, 8'h00, 8'h00, 8'h00, 32'd2999);
        offer_frame(wheel_id, WHEEL_LENGTH, KEY_WHEEL_MUTE, 8'h00, 8'h00, 8'h00, 32'd3000);
        // hold across the timer wrap
        offer_frame(wheel_id, WHEEL_LENGTH, KEY_WHEEL_MUTE, 8'h00, 8'h00, 8'h00,
                    32'hFFFF_FF00);
        offer_frame(wheel_id, WHEEL_LENGTH, KEY_WHEEL_MUTE, 8'h00, 8'h00, 8'h00,
                    32'h0000_06D0);
        // panel press, unknown key press, release twice
        offer_frame(panel_id, 4'd8, KIND_PANEL, 8'hFF, KEY_NEXT_A, STATE_PRESS, 32'd0);
        offer_frame(panel_id, 4'd8, KIND_PANEL, 8'h00, 8'h99, STATE_PRESS, 32'd0);
        offer_frame(panel_id, 4'd8, KIND_PANEL, 8'h00, 8'h00, 8'hFF, 32'd0);
        offer_frame(panel_id, 4'd8, KIND_PANEL, 8'h00, 8'h00, 8'h01, 32'd0);
        // leave aux while a key is down
        offer_frame(wheel_id, WHEEL_LENGTH, KEY_PREV_A, 8'h00, 8'h00, 8'h00, 32'd0);
        offer_frame(panel_id, 4'd2, KIND_SOURCE, SOURCE_MARK, 8'h20, 8'h00, 32'd0);
        // frames hitting both masks: back to aux, then two commands each
        offer_frame(32'hFFFF_FFFF, WHEEL_LENGTH, KIND_SOURCE, SOURCE_MARK, AUX_SOURCE_RST,
                    8'h00, 32'd0);
        offer_frame(32'hFFFF_FFFF, WHEEL_LENGTH, KIND_PANEL, 8'h00, KEY_PREV_A, STATE_PRESS,
                    32'd0);
        offer_frame(32'hFFFF_FFFF, WHEEL_LENGTH, KIND_PANEL, 8'h00, 8'h00, 8'h80, 32'd0);

        // random phases; settings are written in all but phase 0 and the idle pattern repeats every four phases
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            case (phase)
                1: apply_settings(29'h1FFF_FFFF, 29'h1FFF_FFFF, 29'h0000_00FF, 29'h0000_FFFF);
                2: apply_settings('0, '0, '0, '0);
                4: apply_settings(WHEEL_MASK_RST, PANEL_MASK_RST, 29'(AUX_SOURCE_RST),
                                  29'h1FFF_0001);
                6: apply_settings('0, PANEL_MASK_RST, 29'h0ABC_DE08, 29'(HOLD_TIME_RST));
                3, 5, 7:
                    apply_settings(29'($urandom & $urandom), 29'($urandom & $urandom),
                                   29'($urandom_range(255)), 29'($urandom_range(3000)));
                default: ;
            endcase
            tx_idle_pct = (phase % 4 == 1) ? 76 : (phase % 4 == 3) ? 6 : 0;
            rx_idle_pct <= (phase % 4 == 2) ? 76 : (phase % 4 == 3) ? 6 : 0;
            useful = 0;
            while (useful < ITEMS_PER_PHASE)
            begin
                random_frame(got);
                if (got)
                begin
                    useful++;
                    // long receiver hold-off while frames keep coming
                    if (phase == 4 && useful == 40)
                        hold_requests <= hold_requests + 1;
                    // sender pause until all commands are out
                    if (phase == 5 && useful == 60)
                        wait_idle();
                end
            end
        end

        wait_idle();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/cktb_pkg.sv
rtl/cktb_front.sv
rtl/cktb_queue.sv
rtl/cktb_back.sv
rtl/can_key_to_button_translator.sv
tb/can_button_checker.sv
tb/testbench.sv
